// File: rtl/core/tpcs_pkg.sv
// shared types and constants of the triangle projection, cull and shade block
`default_nettype none
package tpcs_pkg;

	// lane and pipeline geometry
	localparam int LANES     = 3;
	localparam int CZ_W      = 36;
	localparam int NUM_W     = 48;
	localparam int DEN_W     = 35;
	localparam int QUO_W     = 16;
	localparam int REM_W     = DEN_W + QUO_W;
	localparam int DIV_LAT   = QUO_W + 2;
	localparam int LANE_LAT  = 4 + DIV_LAT;
	localparam int MERGE_LAT = 6;
	localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;
	localparam int CFG_ADDR_W = 5;

	// rotation, near plane and projection constants
	localparam logic signed [16:0] K571      = 17'sd37421;
	localparam logic signed [16:0] K821      = 17'sd53805;
	localparam logic signed [CZ_W-1:0] NEAR_Q26 = 36'sd13421773;
	localparam logic signed [10:0] FOCAL     = 11'sd340;
	localparam logic signed [10:0] CENTER_X  = 11'sd320;
	localparam logic signed [10:0] CENTER_Y  = 11'sd240;

	// shading and depth constants
	localparam logic signed [15:0] LIGHT_X   = 16'sd6396;
	localparam logic signed [15:0] LIGHT_Y   = -16'sd7995;
	localparam logic signed [15:0] LIGHT_Z   = 16'sd12791;
	localparam logic [19:0] AMBIENT_Q16      = 20'd29491;
	localparam logic [15:0] DIFFUSE_Q16      = 16'd36045;
	localparam logic [19:0] I_MIN_Q16        = 20'd13107;
	localparam logic [19:0] I_MAX_Q16        = 20'd65536;
	localparam logic signed [15:0] THIRD_Q16 = 16'sd21843;
	localparam logic [15:0] DEFAULT_COLOR    = 16'hCE59;

	// register reset values
	localparam logic signed [15:0] CAMERA_Y_RESET = -16'sd4710;
	localparam logic signed [15:0] CAMERA_Z_RESET = 16'sd3277;

	typedef enum logic [2:0] {
		REG_CAMERA_X,
		REG_CAMERA_Y,
		REG_CAMERA_Z,
		REG_OBJECT_COLOR,
		REG_HOVER_OFFSET
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] camera_x;
		logic signed [15:0] camera_y;
		logic signed [15:0] camera_z;
		logic [15:0]        object_color;
		logic signed [15:0] hover_offset;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] vertex0_x;
		logic signed [15:0] vertex0_y;
		logic signed [15:0] vertex0_z;
		logic signed [15:0] vertex1_x;
		logic signed [15:0] vertex1_y;
		logic signed [15:0] vertex1_z;
		logic signed [15:0] vertex2_x;
		logic signed [15:0] vertex2_y;
		logic signed [15:0] vertex2_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} tri_in_t;

	typedef struct packed {
		logic signed [15:0] screen0_x;
		logic signed [15:0] screen0_y;
		logic signed [15:0] screen1_x;
		logic signed [15:0] screen1_y;
		logic signed [15:0] screen2_x;
		logic signed [15:0] screen2_y;
		logic [15:0]        shaded_color;
		logic [15:0]        mean_depth;
	} tri_out_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} normal_t;

	// what one lane reports for its vertex
	typedef struct packed {
		logic signed [15:0]     screen_x;
		logic signed [15:0]     screen_y;
		logic signed [CZ_W-1:0] cz;
		logic                   near;
	} lane_res_t;

endpackage
`default_nettype wire

// File: rtl/core/tpcs_if.sv
// valid/ready channel interfaces for triangle beats and result beats
`default_nettype none
interface tpcs_in_if;
	logic               valid;
	logic               ready;
	tpcs_pkg::tri_in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tpcs_out_if;
	logic               valid;
	logic               ready;
	tpcs_pkg::tri_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tpcs_div.sv
// pipelined signed divide by a positive depth, saturated to 16 bits
`default_nettype none
module tpcs_div (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire logic signed [tpcs_pkg::NUM_W-1:0] num,
	input  wire logic signed [tpcs_pkg::CZ_W-1:0]  den,
	output logic signed [15:0]                   quo
);
	import tpcs_pkg::*;

	logic [NUM_W-1:0] mag_c;
	logic [REM_W-1:0] rem0_c;
	logic             ovf_c;

	logic [REM_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] q_s   [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];

	logic [QUO_W-1:0] qf_c;
	logic [15:0]      sat_c;

	// magnitude and quotient overflow check
	always_comb begin
		mag_c  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		rem0_c = REM_W'(mag_c);
		ovf_c  = rem0_c >= {den[DEN_W-1:0], {QUO_W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem0_c;
			q_s[0]   <= '0;
			den_s[0] <= den[DEN_W-1:0];
			neg_s[0] <= num[NUM_W-1];
			ovf_s[0] <= ovf_c;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int SH = QUO_W - 1 - k;
		logic [REM_W-1:0] dsh_c;
		logic             ge_c;
		always_comb begin
			dsh_c = REM_W'(den_s[k]) << SH;
			ge_c  = rem_s[k] >= dsh_c;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge_c ? rem_s[k] - dsh_c : rem_s[k];
				q_s[k+1]   <= {q_s[k][QUO_W-2:0], ge_c};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// sign and saturation
	always_comb begin
		qf_c = q_s[QUO_W];
		if (ovf_s[QUO_W]) begin
			sat_c = neg_s[QUO_W] ? 16'h8000 : 16'h7FFF;
		end else if (neg_s[QUO_W]) begin
			sat_c = (qf_c > 16'h8000) ? 16'h8000 : 16'(-qf_c);
		end else begin
			sat_c = (qf_c > 16'h7FFF) ? 16'h7FFF : qf_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= sat_c;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/tpcs_lane.sv
// one vertex lane: camera transform, projection and divides
`default_nettype none
module tpcs_lane (
	input  wire                           clk,
	input  wire                           en,
	input  wire logic signed [15:0]       vx,
	input  wire logic signed [15:0]       vy,
	input  wire logic signed [15:0]       vz,
	input  wire tpcs_pkg::cfg_t           cfg,
	output tpcs_pkg::lane_res_t           res
);
	import tpcs_pkg::*;

	logic signed [16:0] rx_s1, ry_s1;
	logic signed [17:0] rz_s1;
	logic signed [16:0] rx_s2;
	logic signed [33:0] p571y_s2, p821y_s2;
	logic signed [34:0] p821z_s2, p571z_s2;
	logic signed [32:0] cx_s3;
	logic signed [CZ_W-1:0] cy_s3, cz_s3;
	logic signed [NUM_W-1:0] numx_s4, numy_s4;
	logic signed [CZ_W-1:0] cz_s4;
	logic near_s4;
	logic signed [CZ_W-1:0] cz_d [DIV_LAT];
	logic near_d [DIV_LAT];
	logic signed [15:0] sx, sy;

	// position relative to camera, hover lift on z
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= 17'(vx) - 17'(cfg.camera_x);
			ry_s1 <= 17'(vy) - 17'(cfg.camera_y);
			rz_s1 <= 18'(vz) + 18'(cfg.hover_offset) - 18'(cfg.camera_z);
		end
	end

	// pitch rotation products
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s2    <= rx_s1;
			p571y_s2 <= ry_s1 * K571;
			p821y_s2 <= ry_s1 * K821;
			p821z_s2 <= rz_s1 * K821;
			p571z_s2 <= rz_s1 * K571;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3 <= {rx_s2, 16'b0};
			cy_s3 <= CZ_W'(p571y_s2) + CZ_W'(p821z_s2);
			cz_s3 <= CZ_W'(p821y_s2) - CZ_W'(p571z_s2);
		end
	end

	// projection numerators and near test
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s4 <= NUM_W'(cz_s3) * CENTER_X + NUM_W'(cx_s3) * FOCAL;
			numy_s4 <= NUM_W'(cz_s3) * CENTER_Y - NUM_W'(cy_s3) * FOCAL;
			cz_s4   <= cz_s3;
			near_s4 <= cz_s3 < NEAR_Q26;
		end
	end

	tpcs_div u_div_x (.clk(clk), .en(en), .num(numx_s4), .den(cz_s4), .quo(sx));
	tpcs_div u_div_y (.clk(clk), .en(en), .num(numy_s4), .den(cz_s4), .quo(sy));

	// depth and near flag ride alongside the divides
	always_ff @(posedge clk) begin
		if (en) begin
			cz_d[0]   <= cz_s4;
			near_d[0] <= near_s4;
			for (int i = 1; i < DIV_LAT; i++) begin
				cz_d[i]   <= cz_d[i-1];
				near_d[i] <= near_d[i-1];
			end
		end
	end

	always_comb begin
		res.screen_x = sx;
		res.screen_y = sy;
		res.cz       = cz_d[DIV_LAT-1];
		res.near     = near_d[DIV_LAT-1];
	end

endmodule
`default_nettype wire

// File: rtl/core/tpcs_merge.sv
// merge of the three lanes: back-face cull, shading and mean depth
`default_nettype none
module tpcs_merge (
	input  wire                      clk,
	input  wire                      en,
	input  wire tpcs_pkg::lane_res_t res [tpcs_pkg::LANES],
	input  wire tpcs_pkg::normal_t   nrm,
	input  wire logic [15:0]         object_color,
	output logic                     keep,
	output tpcs_pkg::tri_out_t       out
);
	import tpcs_pkg::*;

	typedef struct packed {
		logic signed [15:0] x0, y0, x1, y1, x2, y2;
	} crd_t;

	crd_t crd_s1, crd_s2, crd_s3, crd_s4, crd_s5;
	logic drop_s1, drop_s2, drop_s3;
	logic signed [16:0] dx1_s1, dy2_s1, dy1_s1, dx2_s1;
	logic signed [31:0] nlx_s1, nly_s1, nlz_s1;
	logic signed [37:0] zsum_s1;
	logic signed [33:0] pa_s2, pb_s2;
	logic signed [33:0] dot_s2;
	logic signed [53:0] zprod_s2;
	logic signed [34:0] cross_s3;
	logic [30:0] dotp_s3;
	logic signed [21:0] depth_s3;
	logic [46:0] diff_s4;
	logic keep_s4, keep_s5;
	logic [15:0] depth_s4, depth_s5;
	logic [19:0] isum_c;
	logic [16:0] inten_s5;
	logic [15:0] base_c;
	logic [21:0] rp_c, bp_c;
	logic [22:0] gp_c;
	logic [4:0] r_c, b_c;
	logic [5:0] g_c;

	// edge differences, light products, depth sum
	always_ff @(posedge clk) begin
		if (en) begin
			crd_s1  <= {res[0].screen_x, res[0].screen_y, res[1].screen_x,
				res[1].screen_y, res[2].screen_x, res[2].screen_y};
			drop_s1 <= res[0].near | res[1].near | res[2].near;
			dx1_s1  <= 17'(res[1].screen_x) - 17'(res[0].screen_x);
			dy2_s1  <= 17'(res[2].screen_y) - 17'(res[0].screen_y);
			dy1_s1  <= 17'(res[1].screen_y) - 17'(res[0].screen_y);
			dx2_s1  <= 17'(res[2].screen_x) - 17'(res[0].screen_x);
			nlx_s1  <= nrm.nx * LIGHT_X;
			nly_s1  <= nrm.ny * LIGHT_Y;
			nlz_s1  <= nrm.nz * LIGHT_Z;
			zsum_s1 <= 38'(res[0].cz) + 38'(res[1].cz) + 38'(res[2].cz);
		end
	end

	// cross products, dot sum, depth scale
	always_ff @(posedge clk) begin
		if (en) begin
			crd_s2   <= crd_s1;
			drop_s2  <= drop_s1;
			pa_s2    <= dx1_s1 * dy2_s1;
			pb_s2    <= dy1_s1 * dx2_s1;
			dot_s2   <= 34'(nlx_s1) + 34'(nly_s1) + 34'(nlz_s1);
			zprod_s2 <= 54'(zsum_s1) * THIRD_Q16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s3   <= crd_s2;
			drop_s3  <= drop_s2;
			cross_s3 <= 35'(pa_s2) - 35'(pb_s2);
			dotp_s3  <= dot_s2[33] ? '0 : dot_s2[30:0];
			depth_s3 <= zprod_s2[53:32];
		end
	end

	// cull decision, diffuse product, depth saturation
	always_ff @(posedge clk) begin
		if (en) begin
			crd_s4  <= crd_s3;
			keep_s4 <= !drop_s3 && cross_s3[34];
			diff_s4 <= 47'(dotp_s3) * 47'(DIFFUSE_Q16);
			if (depth_s3[21]) begin
				depth_s4 <= '0;
			end else if (depth_s3 > 22'sd65535) begin
				depth_s4 <= 16'hFFFF;
			end else begin
				depth_s4 <= depth_s3[15:0];
			end
		end
	end

	// intensity with clamp
	always_comb begin
		isum_c = AMBIENT_Q16 + 20'(diff_s4[46:28]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s5   <= crd_s4;
			keep_s5  <= keep_s4;
			depth_s5 <= depth_s4;
			if (isum_c > I_MAX_Q16) begin
				inten_s5 <= I_MAX_Q16[16:0];
			end else if (isum_c < I_MIN_Q16) begin
				inten_s5 <= I_MIN_Q16[16:0];
			end else begin
				inten_s5 <= isum_c[16:0];
			end
		end
	end

	// color channel scaling
	always_comb begin
		base_c = (object_color != '0) ? object_color : DEFAULT_COLOR;
		rp_c   = 22'(base_c[15:11]) * 22'(inten_s5);
		gp_c   = 23'(base_c[10:5]) * 23'(inten_s5);
		bp_c   = 22'(base_c[4:0]) * 22'(inten_s5);
		r_c    = rp_c[21] ? 5'h1F : rp_c[20:16];
		g_c    = gp_c[22] ? 6'h3F : gp_c[21:16];
		b_c    = bp_c[21] ? 5'h1F : bp_c[20:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep             <= keep_s5;
			out.screen0_x    <= crd_s5.x0;
			out.screen0_y    <= crd_s5.y0;
			out.screen1_x    <= crd_s5.x1;
			out.screen1_y    <= crd_s5.y1;
			out.screen2_x    <= crd_s5.x2;
			out.screen2_y    <= crd_s5.y2;
			out.shaded_color <= {r_c, g_c, b_c};
			out.mean_depth   <= depth_s5;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/triangle_project_cull_shade.sv
// triangle projection, back-face cull and shading, top level
// Takes one triangle beat on tri_in (three world vertices in Q6.10 and a
// normal in Q1.14) and gives at most one result beat on tri_out: three
// saturated screen positions, an RGB565 shaded color and the mean depth.
// Triangles behind the near plane or not facing the viewer give no beat.
// Three vertex lanes work in parallel; each divide runs one quotient bit per
// stage, and the lanes and the merge make a pipeline of 28 stages, followed
// by the output register. One triangle is accepted every cycle while
// tri_in.ready is high. When the receiver stalls the output register holds
// its beat, and the pipeline keeps moving until a kept triangle reaches its
// last stage; then tri_in.ready drops until the beat is taken. Reset empties
// the pipeline and loads the register defaults; no clearing pass follows.
// The APB port writes the registers; the user must change them only while
// no triangle is in flight, since the block itself does not enforce it.
`default_nettype none
module triangle_project_cull_shade (
	input  wire                                   clk,
	input  wire                                   arst_n,
	tpcs_in_if.sink                               tri_in,
	tpcs_out_if.source                            tri_out,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire logic [tpcs_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import tpcs_pkg::*;

	cfg_t cfg_q;
	cfg_reg_t reg_sel;
	logic en;
	logic load;
	logic [PIPE_LAT-1:0] vld_q;
	normal_t nrm_q [LANE_LAT];
	logic signed [15:0] vx [LANES];
	logic signed [15:0] vy [LANES];
	logic signed [15:0] vz [LANES];
	lane_res_t lres [LANES];
	logic m_keep;
	tri_out_t m_out;
	logic out_valid_q;
	tri_out_t out_q;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_x     <= '0;
			cfg_q.camera_y     <= CAMERA_Y_RESET;
			cfg_q.camera_z     <= CAMERA_Z_RESET;
			cfg_q.object_color <= '0;
			cfg_q.hover_offset <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_CAMERA_X:     cfg_q.camera_x     <= pwdata[15:0];
				REG_CAMERA_Y:     cfg_q.camera_y     <= pwdata[15:0];
				REG_CAMERA_Z:     cfg_q.camera_z     <= pwdata[15:0];
				REG_OBJECT_COLOR: cfg_q.object_color <= pwdata[15:0];
				REG_HOVER_OFFSET: cfg_q.hover_offset <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CAMERA_X:     prdata = {16'b0, cfg_q.camera_x};
			REG_CAMERA_Y:     prdata = {16'b0, cfg_q.camera_y};
			REG_CAMERA_Z:     prdata = {16'b0, cfg_q.camera_z};
			REG_OBJECT_COLOR: prdata = {16'b0, cfg_q.object_color};
			REG_HOVER_OFFSET: prdata = {16'b0, cfg_q.hover_offset};
			default:          prdata = '0;
		endcase
	end

	// pipeline advances unless a kept beat is blocked at the output
	assign en           = !(vld_q[PIPE_LAT-1] && m_keep && out_valid_q && !tri_out.ready);
	assign tri_in.ready = en;
	assign load         = en && vld_q[PIPE_LAT-1] && m_keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], tri_in.valid};
		end
	end

	// normal waits for the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			nrm_q[0] <= {tri_in.data.normal_x, tri_in.data.normal_y, tri_in.data.normal_z};
			for (int i = 1; i < LANE_LAT; i++) begin
				nrm_q[i] <= nrm_q[i-1];
			end
		end
	end

	// vertex lanes
	always_comb begin
		vx[0] = tri_in.data.vertex0_x;
		vy[0] = tri_in.data.vertex0_y;
		vz[0] = tri_in.data.vertex0_z;
		vx[1] = tri_in.data.vertex1_x;
		vy[1] = tri_in.data.vertex1_y;
		vz[1] = tri_in.data.vertex1_z;
		vx[2] = tri_in.data.vertex2_x;
		vy[2] = tri_in.data.vertex2_y;
		vz[2] = tri_in.data.vertex2_z;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		tpcs_lane u_lane (
			.clk (clk),
			.en  (en),
			.vx  (vx[l]),
			.vy  (vy[l]),
			.vz  (vz[l]),
			.cfg (cfg_q),
			.res (lres[l])
		);
	end

	tpcs_merge u_merge (
		.clk          (clk),
		.en           (en),
		.res          (lres),
		.nrm          (nrm_q[LANE_LAT-1]),
		.object_color (cfg_q.object_color),
		.keep         (m_keep),
		.out          (m_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (tri_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= m_out;
		end
	end

	assign tri_out.valid = out_valid_q;
	assign tri_out.data  = out_q;

endmodule
`default_nettype wire
